FILE: hdl/set_assoc_cache_timestamp_lru_defines.svh
// assertion macros for the set-associative tag store
// used by set_assoc_cache_timestamp_lru.sv; expects i_clk and i_rst_n in scope
`ifndef SET_ASSOC_CACHE_TIMESTAMP_LRU_DEFINES_SVH
`define SET_ASSOC_CACHE_TIMESTAMP_LRU_DEFINES_SVH

// same-cycle implication, off while in reset
`define SACL_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, off while in reset
`define SACL_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/sacl_pkg.sv
// shared constants, codes and store types of the set-associative tag store
// no dependencies; imported by every module of the block
package sacl_pkg;

    localparam int SETS   = 64;
    localparam int WAYS   = 8;
    localparam int SET_W  = (SETS > 1) ? $clog2(SETS) : 1;
    localparam int WAY_W  = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int LINE_W = SET_W + WAY_W;

    localparam int TIME_W = 64;
    localparam int ACC_W  = 32;
    localparam int OFF_W  = 4;
    localparam int LAT_W  = 10;
    localparam int OP_W   = 2;
    localparam int RES_SET_W = 6;
    localparam int RES_WAY_W = 3;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 10;

    localparam int IN_DATA_W  = 176;
    localparam int OUT_DATA_W = 112;

    // request codes
    localparam logic [OP_W-1:0] OP_READ    = 2'd0;
    localparam logic [OP_W-1:0] OP_WRITE   = 2'd1;
    localparam logic [OP_W-1:0] OP_INSTALL = 2'd2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_LINE_OFFSET = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HIT_LATENCY = 1'd1;

    typedef struct packed {
        logic [WAYS-1:0] valid;
        logic [WAYS-1:0] dirty;
    } t_meta;

    typedef struct packed {
        logic [TIME_W-1:0] tag;
        logic [TIME_W-1:0] recency;
        logic [TIME_W-1:0] ready;
    } t_entry;

    typedef struct packed {
        logic             meta_rd;
        logic             meta_wr;
        logic             ent_rd;
        logic             ent_wr;
        logic [SET_W-1:0] set;
        logic [WAY_W-1:0] way;
        t_meta            meta_wdata;
        t_entry           ent_wdata;
    } t_store_cmd;

    typedef struct packed {
        logic [TIME_W-1:0]    victim_tag;
        logic                 victim_dirty;
        logic                 replaced;
        logic [RES_WAY_W-1:0] way_used;
        logic [RES_SET_W-1:0] set_index;
        logic [ACC_W-1:0]     new_accumulated_time;
        logic                 hit;
    } t_result;

endpackage

FILE: hdl/sacl_alu.sv
// shared 64-bit add/subtract unit with carry out
// depends on sacl_pkg; carry high on a subtract means no borrow
module sacl_alu (
    input  logic [sacl_pkg::TIME_W-1:0] i_a,
    input  logic [sacl_pkg::TIME_W-1:0] i_b,
    input  logic                        i_sub,
    output logic [sacl_pkg::TIME_W:0]   o_res
);
    import sacl_pkg::*;

    logic [TIME_W-1:0] w_b;

    assign w_b   = i_sub ? ~i_b : i_b;
    assign o_res = {1'b0, i_a} + {1'b0, w_b} + {{TIME_W{1'b0}}, i_sub};

endmodule

FILE: hdl/sacl_store.sv
// per-set metadata rows and per-line tag/recency/ready memory
// depends on sacl_pkg; read data registered, rows cleared by per-set valid flops
module sacl_store (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  sacl_pkg::t_store_cmd i_cmd,
    output sacl_pkg::t_meta      o_meta,
    output sacl_pkg::t_entry     o_entry
);
    import sacl_pkg::*;

    t_meta             r_meta_mem [SETS];
    t_entry            r_ent_mem  [SETS*WAYS];
    logic [SETS-1:0]   r_row_ok;
    logic              r_meta_ok_q;
    t_meta             r_meta_q;
    t_entry            r_ent_q;
    logic [LINE_W-1:0] w_line;

    assign w_line = {i_cmd.set, i_cmd.way};

    // row valid flops: a row never written reads as all invalid, all clean
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_ok    <= '0;
            r_meta_ok_q <= 1'b0;
        end else begin
            if (i_cmd.meta_wr) begin
                r_row_ok[i_cmd.set] <= 1'b1;
            end
            if (i_cmd.meta_rd) begin
                r_meta_ok_q <= r_row_ok[i_cmd.set];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.meta_wr) begin
            r_meta_mem[i_cmd.set] <= i_cmd.meta_wdata;
        end
        if (i_cmd.meta_rd) begin
            r_meta_q <= r_meta_mem[i_cmd.set];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.ent_wr) begin
            r_ent_mem[w_line] <= i_cmd.ent_wdata;
        end
        if (i_cmd.ent_rd) begin
            r_ent_q <= r_ent_mem[w_line];
        end
    end

    assign o_meta  = r_meta_ok_q ? r_meta_q : '0;
    assign o_entry = r_ent_q;

endmodule

FILE: hdl/set_assoc_cache_timestamp_lru.sv
// top level of the set-associative tag store with timestamp lru replacement
// depends on sacl_pkg, sacl_alu, sacl_store and the assertion macro header
//
//  channel | dir | handshake                  | payload
//  --------+-----+----------------------------+--------------------------------------
//  s       | in  | i_s_tvalid / o_s_tready    | tuser: operation; tdata: request
//  m       | out | o_m_tvalid / i_m_tready    | tdata: result of one request
//  cfg     | in  | i_cfg_valid / o_cfg_ready  | i_cfg_index, i_cfg_data
//
// per request, the ways of the set are read one at a time from the line memory
// and each goes through the shared adder, then two more adder passes settle the
// timing before write-back.
// the input is ready only in idle; the finished beat sits in an output
// register, so the next request is taken while it waits.
// reset is synchronous, active low, and clears all lines at once through the
// per-set row valid flops: no clearing pass.
`include "set_assoc_cache_timestamp_lru_defines.svh"

module set_assoc_cache_timestamp_lru (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // request beat
    input  logic                               i_s_tvalid,
    output logic                               o_s_tready,
    // [63:0] address, [127:64] now, [159:128] accumulated_time,
    // [169:160] fill_latency, [175:170] zero
    input  logic [sacl_pkg::IN_DATA_W-1:0]     i_s_tdata,
    // [1:0] operation
    input  logic [sacl_pkg::OP_W-1:0]          i_s_tuser,
    // result beat
    output logic                               o_m_tvalid,
    input  logic                               i_m_tready,
    // [0] hit, [32:1] new_accumulated_time, [38:33] set_index, [41:39] way_used,
    // [42] replaced, [43] victim_dirty, [107:44] victim_tag, [111:108] zero
    output logic [sacl_pkg::OUT_DATA_W-1:0]    o_m_tdata,
    // register writes
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [sacl_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [sacl_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import sacl_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_TAG  = 7'b0000010,
        S_RD   = 7'b0000100,
        S_CMP  = 7'b0001000,
        S_CHK  = 7'b0010000,
        S_SUM  = 7'b0100000,
        S_DONE = 7'b1000000
    } t_state;

    t_state r_state, n_state;

    // configuration
    logic [OFF_W-1:0]  r_off;
    logic [LAT_W-1:0]  r_hl;

    // captured request
    logic [OP_W-1:0]   r_op;
    logic [TIME_W-1:0] r_addr;
    logic [TIME_W-1:0] r_now;
    logic [ACC_W-1:0]  r_acc;
    logic [LAT_W-1:0]  r_fill;
    logic [TIME_W-1:0] r_tag;

    // way scan
    logic [WAY_W-1:0]  r_way;
    logic              r_found;
    logic [WAY_W-1:0]  r_hit_way;
    logic [TIME_W-1:0] r_hit_ready;
    logic [TIME_W-1:0] r_best_rec;
    logic [WAY_W-1:0]  r_best_way;
    logic [TIME_W-1:0] r_best_tag;

    // timing results
    logic              r_filling;
    logic [TIME_W-1:0] r_diff;
    logic [ACC_W-1:0]  r_new_acc;
    logic [TIME_W-1:0] r_new_rec;
    logic [TIME_W-1:0] r_new_ready;

    // output register
    logic              r_out_valid;
    t_result           r_res;

    // store and shared adder
    t_store_cmd        w_cmd;
    t_meta             w_meta;
    t_entry            w_ent;
    logic [TIME_W-1:0] w_alu_a;
    logic [TIME_W-1:0] w_alu_b;
    logic              w_alu_sub;
    logic [TIME_W:0]   w_alu;

    logic [TIME_W-1:0] w_tag_calc;
    logic [SET_W-1:0]  w_set;
    logic              w_is_rw;
    logic              w_match;
    logic              w_less;
    logic [ACC_W-1:0]  w_sat_acc;
    logic              w_alloc;
    logic              w_any_inv;
    logic [WAY_W-1:0]  w_inv_way;
    logic [WAY_W-1:0]  w_vict_way;
    logic [WAY_W-1:0]  w_use_way;
    logic              w_evict;
    logic              w_out_free;
    logic              w_in_acc;
    logic              w_fire;

    assign o_s_tready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign w_in_acc    = i_s_tvalid && o_s_tready;
    assign w_out_free  = !r_out_valid || i_m_tready;
    assign w_fire      = (r_state == S_DONE) && w_out_free;

    assign w_tag_calc = r_addr >> r_off;
    assign w_set      = r_tag[SET_W-1:0];
    assign w_is_rw    = (r_op == OP_READ) || (r_op == OP_WRITE);

    // a way matches only when its valid bit is set
    assign w_match = w_meta.valid[r_way] && (w_ent.tag == r_tag) && w_is_rw;
    // carry out of a subtract is the no-borrow flag
    assign w_less  = !w_alu[TIME_W];
    assign w_sat_acc = (|w_alu[TIME_W:ACC_W]) ? '1 : w_alu[ACC_W-1:0];

    // victim: first invalid way, else least recent (lowest way on ties)
    always_comb begin
        w_inv_way = '0;
        for (int w = WAYS - 1; w >= 0; w--) begin
            if (!w_meta.valid[w]) begin
                w_inv_way = WAY_W'(w);
            end
        end
    end

    assign w_any_inv  = !(&w_meta.valid);
    assign w_vict_way = w_any_inv ? w_inv_way : r_best_way;
    assign w_alloc    = ((r_op == OP_WRITE) && !r_found) || (r_op == OP_INSTALL);
    assign w_evict    = w_alloc && !w_any_inv;
    assign w_use_way  = r_found ? r_hit_way : (w_alloc ? w_vict_way : '0);

    // shared adder operand select
    always_comb begin
        w_alu_a   = r_now;
        w_alu_b   = r_best_rec;
        w_alu_sub = 1'b1;
        unique case (r_state)
            S_CMP: begin
                w_alu_a   = w_ent.recency;
                w_alu_b   = r_best_rec;
                w_alu_sub = 1'b1;
            end
            S_CHK: begin
                w_alu_a   = r_hit_ready;
                w_alu_b   = r_now;
                w_alu_sub = 1'b1;
            end
            S_SUM: begin
                w_alu_sub = 1'b0;
                if (r_op == OP_READ) begin
                    w_alu_a = TIME_W'(r_acc);
                    w_alu_b = (r_found && r_filling) ? r_diff : TIME_W'(r_hl);
                end else if (r_found) begin
                    w_alu_a = r_hit_ready;
                    w_alu_b = TIME_W'(r_hl);
                end else begin
                    w_alu_a = r_now;
                    w_alu_b = TIME_W'(r_fill);
                end
            end
            default: begin
            end
        endcase
    end

    sacl_alu u_alu (
        .i_a   (w_alu_a),
        .i_b   (w_alu_b),
        .i_sub (w_alu_sub),
        .o_res (w_alu)
    );

    // store commands
    always_comb begin
        w_cmd         = '0;
        w_cmd.meta_rd = (r_state == S_TAG);
        w_cmd.set     = (r_state == S_TAG) ? w_tag_calc[SET_W-1:0] : w_set;
        w_cmd.ent_rd  = (r_state == S_RD);
        w_cmd.way     = (r_state == S_DONE) ? w_use_way : r_way;
        w_cmd.ent_wr  = w_fire && (r_found || w_alloc);
        w_cmd.meta_wr = w_fire && (w_alloc || (r_found && (r_op == OP_WRITE)));
        w_cmd.ent_wdata.tag     = r_tag;
        w_cmd.ent_wdata.recency = r_new_rec;
        w_cmd.ent_wdata.ready   = r_found ? r_hit_ready : r_new_ready;
        w_cmd.meta_wdata.valid  = w_meta.valid | (WAYS'(1) << w_use_way);
        w_cmd.meta_wdata.dirty  = (r_op == OP_INSTALL)
                                ? (w_meta.dirty & ~(WAYS'(1) << w_use_way))
                                : (w_meta.dirty | (WAYS'(1) << w_use_way));
    end

    sacl_store u_store (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_cmd),
        .o_meta  (w_meta),
        .o_entry (w_ent)
    );

    // sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (w_in_acc) n_state = S_TAG;
            S_TAG:  n_state = S_RD;
            S_RD:   n_state = S_CMP;
            S_CMP:  n_state = (r_way == WAY_W'(WAYS - 1)) ? S_CHK : S_RD;
            S_CHK:  n_state = S_SUM;
            S_SUM:  n_state = S_DONE;
            S_DONE: if (w_out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_off       <= OFF_W'(6);
            r_hl        <= LAT_W'(1);
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    CFG_LINE_OFFSET: r_off <= i_cfg_data[OFF_W-1:0];
                    CFG_HIT_LATENCY: r_hl  <= i_cfg_data[LAT_W-1:0];
                    default: begin
                    end
                endcase
            end
            if (w_fire) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_op   <= i_s_tuser;
            r_addr <= i_s_tdata[63:0];
            r_now  <= i_s_tdata[127:64];
            r_acc  <= i_s_tdata[159:128];
            r_fill <= i_s_tdata[169:160];
        end

        if (r_state == S_TAG) begin
            r_tag   <= w_tag_calc;
            r_way   <= '0;
            r_found <= 1'b0;
        end

        // one way per pass: tag match and running minimum of recency
        if (r_state == S_CMP) begin
            if (w_match && !r_found) begin
                r_found     <= 1'b1;
                r_hit_way   <= r_way;
                r_hit_ready <= w_ent.ready;
            end
            if ((r_way == '0) || w_less) begin
                r_best_rec <= w_ent.recency;
                r_best_way <= r_way;
                r_best_tag <= w_ent.tag;
            end
            r_way <= r_way + WAY_W'(1);
        end

        // line still filling when ready - now is positive
        if (r_state == S_CHK) begin
            r_diff    <= w_alu[TIME_W-1:0];
            r_filling <= w_alu[TIME_W] && (|w_alu[TIME_W-1:0]);
        end

        if (r_state == S_SUM) begin
            r_new_acc   <= r_acc;
            r_new_ready <= r_now;
            r_new_rec   <= r_now;
            if (r_op == OP_READ) begin
                r_new_acc <= w_sat_acc;
                if (r_found && r_filling) begin
                    r_new_rec <= TIME_W'(w_sat_acc);
                end
            end else if (r_found) begin
                if (r_filling) begin
                    r_new_rec <= w_alu[TIME_W-1:0];
                end
            end else if (r_op == OP_INSTALL) begin
                r_new_ready <= w_alu[TIME_W-1:0];
                r_new_rec   <= w_alu[TIME_W-1:0];
            end
        end

        if (w_fire) begin
            r_res.hit                  <= r_found;
            r_res.new_accumulated_time <= r_new_acc;
            r_res.set_index            <= RES_SET_W'(w_set);
            r_res.way_used             <= RES_WAY_W'(w_use_way);
            r_res.replaced             <= w_evict;
            r_res.victim_dirty         <= w_evict && w_meta.dirty[w_vict_way];
            r_res.victim_tag           <= w_evict ? r_best_tag : '0;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {{(OUT_DATA_W - $bits(t_result)){1'b0}}, r_res};

    `SACL_ASSERT_NXT(a_accept_starts, w_in_acc, r_state == S_TAG, "accepted beat did not start a lookup")
    `SACL_ASSERT_IMP(a_out_from_done, $rose(r_out_valid), $past(r_state == S_DONE), "result beat raised outside write-back")
    `SACL_ASSERT_NXT(a_hit_no_evict, w_fire, !(r_res.hit && r_res.replaced), "hit reported together with an eviction")

endmodule

FILE: verif/sacl_tag_checker.sv
`timescale 1ns / 1ps
// result checker for the set-associative tag store: mirrors the tag, dirty,
// recency and ready state per line and compares every result beat; uses sacl_pkg
module sacl_tag_checker
    import sacl_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_tvalid,
    input  logic                  i_s_tready,
    input  logic [IN_DATA_W-1:0]  i_s_tdata,
    input  logic [OP_W-1:0]       i_s_tuser,
    input  logic                  i_m_tvalid,
    input  logic                  i_m_tready,
    input  logic [OUT_DATA_W-1:0] i_m_tdata,
    input  logic                  i_cfg_valid,
    input  logic                  i_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output int                    o_mismatch_count,
    output int                    o_pending,
    output int                    o_hits,
    output int                    o_evictions,
    output int                    o_dirty_evictions
);

    localparam int LINES         = SETS * WAYS;
    localparam int MAX_REPORTS   = 10;
    localparam int RESET_OFFSET  = 6;
    localparam int RESET_HIT_LAT = 1;

    logic              way_valid   [LINES];
    logic              way_dirty   [LINES];
    logic [TIME_W-1:0] way_tag     [LINES];
    logic [TIME_W-1:0] way_recency [LINES];
    logic [TIME_W-1:0] way_ready   [LINES];

    logic [OFF_W-1:0]  offset_bits;
    logic [LAT_W-1:0]  hit_lat;

    t_result           expected_results[$];
    int                result_no;

    function automatic logic [ACC_W-1:0] add_saturated(input logic [ACC_W-1:0] base,
                                                       input logic [TIME_W-1:0] extra);
        logic [TIME_W-1:0] sum;
        if (extra >= TIME_W'({ACC_W{1'b1}}))
            return '1;
        sum = TIME_W'(base) + extra;
        return (sum > TIME_W'({ACC_W{1'b1}})) ? '1 : sum[ACC_W-1:0];
    endfunction

    // lookup, fill or write of one request against the mirrored set
    function automatic t_result predict_lookup(input logic [OP_W-1:0]   op,
                                               input logic [TIME_W-1:0] addr,
                                               input logic [TIME_W-1:0] now,
                                               input logic [ACC_W-1:0]  acc,
                                               input logic [LAT_W-1:0]  fill);
        t_result           r;
        logic [TIME_W-1:0] tag;
        int                base;
        int                found;
        int                way;
        int                line;
        int                w;
        tag   = addr >> offset_bits;
        base  = int'(tag[SET_W-1:0]) * WAYS;
        r     = '0;
        r.new_accumulated_time = acc;
        r.set_index = RES_SET_W'(tag[SET_W-1:0]);
        found = -1;
        if (op == OP_READ || op == OP_WRITE)
            for (w = 0; w < WAYS; w++)
                if (found < 0 && way_valid[base + w] && way_tag[base + w] == tag)
                    found = w;
        case (op)
            OP_READ: begin
                if (found >= 0) begin
                    line = base + found;
                    r.hit = 1'b1;
                    r.way_used = RES_WAY_W'(found);
                    if (way_ready[line] <= now) begin
                        way_recency[line] = now;
                        r.new_accumulated_time = add_saturated(acc, TIME_W'(hit_lat));
                    end else begin
                        // line still filling: wait for it, recency takes the new time
                        r.new_accumulated_time = add_saturated(acc, way_ready[line] - now);
                        way_recency[line] = TIME_W'(r.new_accumulated_time);
                    end
                end else begin
                    r.new_accumulated_time = add_saturated(acc, TIME_W'(hit_lat));
                end
            end
            OP_WRITE, OP_INSTALL: begin
                if (found >= 0) begin
                    line = base + found;
                    r.hit = 1'b1;
                    r.way_used = RES_WAY_W'(found);
                    way_dirty[line] = 1'b1;
                    if (way_ready[line] <= now)
                        way_recency[line] = now;
                    else
                        way_recency[line] = way_ready[line] + TIME_W'(hit_lat);
                end else begin
                    // first empty way, else lowest recency, lowest way on ties
                    way = -1;
                    for (w = 0; w < WAYS; w++)
                        if (way < 0 && !way_valid[base + w])
                            way = w;
                    if (way < 0) begin
                        way = 0;
                        for (w = 1; w < WAYS; w++)
                            if (way_recency[base + w] < way_recency[base + way])
                                way = w;
                    end
                    line = base + way;
                    r.way_used = RES_WAY_W'(way);
                    if (way_valid[line]) begin
                        r.replaced     = 1'b1;
                        r.victim_dirty = way_dirty[line];
                        r.victim_tag   = way_tag[line];
                    end
                    way_tag[line]   = tag;
                    way_valid[line] = 1'b1;
                    if (op == OP_WRITE) begin
                        way_dirty[line]   = 1'b1;
                        way_ready[line]   = now;
                        way_recency[line] = now;
                    end else begin
                        way_dirty[line]   = 1'b0;
                        way_ready[line]   = now + TIME_W'(fill);
                        way_recency[line] = now + TIME_W'(fill);
                    end
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    task automatic check_result(input t_result got);
        t_result want;
        logic    bad;
        result_no++;
        if (expected_results.size() == 0) begin
            o_mismatch_count++;
            if (o_mismatch_count <= MAX_REPORTS)
                $display("result %0d arrived with no request outstanding: %h", result_no, got);
            return;
        end
        want = expected_results.pop_front();
        bad  = (got.hit != want.hit)
            || (got.new_accumulated_time != want.new_accumulated_time)
            || (got.set_index != want.set_index)
            || (got.way_used != want.way_used)
            || (got.replaced != want.replaced)
            || (got.victim_dirty != want.victim_dirty)
            || (got.victim_tag != want.victim_tag);
        if (bad) begin
            o_mismatch_count++;
            if (o_mismatch_count <= MAX_REPORTS) begin
                $display("result %0d mismatch, expected / actual:", result_no);
                $display("  hit %0d/%0d time %h/%h set %0d/%0d way %0d/%0d",
                         want.hit, got.hit, want.new_accumulated_time,
                         got.new_accumulated_time, want.set_index, got.set_index,
                         want.way_used, got.way_used);
                $display("  replaced %0d/%0d victim dirty %0d/%0d victim tag %h/%h",
                         want.replaced, got.replaced, want.victim_dirty, got.victim_dirty,
                         want.victim_tag, got.victim_tag);
            end
        end
    endtask

    always @(posedge i_clk) begin
        t_result predicted;
        if (!i_rst_n) begin
            for (int i = 0; i < LINES; i++) begin
                way_valid[i]   = 1'b0;
                way_dirty[i]   = 1'b0;
                way_tag[i]     = '0;
                way_recency[i] = '0;
                way_ready[i]   = '0;
            end
            offset_bits = OFF_W'(RESET_OFFSET);
            hit_lat     = LAT_W'(RESET_HIT_LAT);
            expected_results.delete();
            result_no         = 0;
            o_mismatch_count  = 0;
            o_pending         = 0;
            o_hits            = 0;
            o_evictions       = 0;
            o_dirty_evictions = 0;
        end else begin
            if (i_m_tvalid && i_m_tready)
                check_result(t_result'(i_m_tdata[$bits(t_result)-1:0]));
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_LINE_OFFSET: offset_bits = i_cfg_data[OFF_W-1:0];
                    CFG_HIT_LATENCY: hit_lat     = i_cfg_data[LAT_W-1:0];
                    default: ;
                endcase
            end
            if (i_s_tvalid && i_s_tready) begin
                predicted = predict_lookup(i_s_tuser,
                                           i_s_tdata[TIME_W-1:0],
                                           i_s_tdata[2*TIME_W-1:TIME_W],
                                           i_s_tdata[2*TIME_W +: ACC_W],
                                           i_s_tdata[2*TIME_W+ACC_W +: LAT_W]);
                o_hits            += predicted.hit;
                o_evictions       += predicted.replaced;
                o_dirty_evictions += predicted.victim_dirty;
                expected_results.push_back(predicted);
            end
            o_pending = expected_results.size();
        end
    end

endmodule

FILE: verif/set_assoc_cache_timestamp_lru_tb.sv
`timescale 1ns / 1ps
// stimulus and verdict for the set-associative tag store with timestamp lru
// depends on sacl_pkg, set_assoc_cache_timestamp_lru and sacl_tag_checker
module set_assoc_cache_timestamp_lru_tb;
    import sacl_pkg::*;

    // operation code the block leaves undefined: must change nothing
    localparam logic [OP_W-1:0] OP_UNDEFINED = 2'd3;

    localparam int REQ_CYCLES   = 2 * WAYS + 5;
    localparam int IDLE_PCT     = 22;
    localparam int RESET_CYCLES = 7;
    localparam int RESET_OFFSET = 6;
    localparam int PHASES       = 5;
    localparam int PHASE_ITEMS  = 330;
    localparam int POOL         = 12;
    localparam int HOT_SETS     = 4;
    localparam int CALM_FIRST   = 400;           // no idling on either side in here
    localparam int CALM_LAST    = 520;
    localparam int HOLD_AT      = 800;           // result sink holds off once here
    localparam int HOLD_CYCLES  = 300;
    localparam int CYCLE_LIMIT  = 400000;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_s_tvalid  = 1'b0;
    logic                  o_s_tready;
    logic [IN_DATA_W-1:0]  i_s_tdata   = '0;
    logic [OP_W-1:0]       i_s_tuser   = OP_READ;
    logic                  o_m_tvalid;
    logic                  i_m_tready  = 1'b0;
    logic [OUT_DATA_W-1:0] o_m_tdata;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = CFG_LINE_OFFSET;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;

    int                    mismatch_count;
    int                    pending;
    int                    hit_total;
    int                    eviction_total;
    int                    dirty_eviction_total;

    int                    sent_count  = 0;
    int                    cycle_count = 0;
    logic                  sink_hold   = 1'b0;
    logic                  calm;
    logic [OFF_W-1:0]      cur_offset  = OFF_W'(RESET_OFFSET);
    logic [TIME_W-1:0]     clock_now   = '0;
    logic [TIME_W-1:0]     tag_pool [POOL];

    always #2 i_clk = ~i_clk;

    set_assoc_cache_timestamp_lru dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    sacl_tag_checker u_checker (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_s_tvalid        (i_s_tvalid),
        .i_s_tready        (o_s_tready),
        .i_s_tdata         (i_s_tdata),
        .i_s_tuser         (i_s_tuser),
        .i_m_tvalid        (o_m_tvalid),
        .i_m_tready        (i_m_tready),
        .i_m_tdata         (o_m_tdata),
        .i_cfg_valid       (i_cfg_valid),
        .i_cfg_ready       (o_cfg_ready),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .o_mismatch_count  (mismatch_count),
        .o_pending         (pending),
        .o_hits            (hit_total),
        .o_evictions       (eviction_total),
        .o_dirty_evictions (dirty_eviction_total)
    );

    // sent_count moves at rising edges, so the falling-edge drivers see it settled
    assign calm = (sent_count >= CALM_FIRST) && (sent_count < CALM_LAST);

    // result sink: random stalls, none in the calm stretch, stalled throughout while holding
    always @(negedge i_clk)
        i_m_tready <= !sink_hold && (calm || $urandom_range(0, 99) >= IDLE_PCT);

    // one long hold-off on the result side so the output register and then the
    // request side back up while requests keep being offered
    initial begin : sink_holdoff
        wait (sent_count >= HOLD_AT);
        @(posedge i_clk);
        sink_hold = 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        sink_hold = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timed out after %0d cycles with %0d results outstanding",
                     cycle_count, pending);
            $display("Simulation FAILED");
            $finish;
        end
    end

    // byte address of a line: {pool tag, set} placed above the offset bits
    function automatic logic [TIME_W-1:0] line_address(input logic [TIME_W-1:0] hi,
                                                       input int set_no);
        return ((hi << SET_W) | TIME_W'(set_no)) << cur_offset;
    endfunction

    // mostly a few hot sets and a small tag pool so lines hit and get evicted,
    // with some fully random addresses as noise
    function automatic logic [TIME_W-1:0] pick_address();
        logic [TIME_W-1:0] low_mask;
        int                set_no;
        if ($urandom_range(0, 99) < 15)
            return {$urandom, $urandom};
        set_no   = ($urandom_range(0, 99) < 70) ? $urandom_range(0, HOT_SETS - 1)
                                                 : $urandom_range(0, SETS - 1);
        low_mask = (TIME_W'(1) << cur_offset) - 1;
        return line_address(tag_pool[$urandom_range(0, POOL - 1)], set_no)
             | ({$urandom, $urandom} & low_mask);
    endfunction

    // cycle count mostly creeps forward, so fills are often still in flight;
    // now and then it jumps anywhere, including just below the wrap
    function automatic logic [TIME_W-1:0] pick_now();
        int r;
        r = $urandom_range(0, 99);
        if (r < 3)
            clock_now = {$urandom, $urandom};
        else if (r < 5)
            clock_now = '1 - TIME_W'($urandom_range(0, 2000));
        else
            clock_now = clock_now + TIME_W'($urandom_range(0, 30));
        return clock_now;
    endfunction

    function automatic logic [ACC_W-1:0] pick_time();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40)
            return $urandom;
        else if (r < 60)
            return '1 - ACC_W'($urandom_range(0, 2000));
        return ACC_W'($urandom_range(0, 5000));
    endfunction

    function automatic logic [OP_W-1:0] pick_op();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40)
            return OP_READ;
        else if (r < 65)
            return OP_WRITE;
        else if (r < 95)
            return OP_INSTALL;
        return OP_UNDEFINED;
    endfunction

    // entered at a falling edge; returns at the falling edge after the beat is taken
    // with tvalid still high, so a following beat keeps it up without a glitch
    task automatic send_request(input logic [OP_W-1:0]   op,
                                input logic [TIME_W-1:0] addr,
                                input logic [TIME_W-1:0] now,
                                input logic [ACC_W-1:0]  acc,
                                input logic [LAT_W-1:0]  fill);
        logic [IN_DATA_W-1:0] beat;
        if (!calm)
            while ($urandom_range(0, 99) < IDLE_PCT) begin
                i_s_tvalid <= 1'b0;
                @(negedge i_clk);
            end
        beat = '0;
        beat[TIME_W-1:0]                = addr;
        beat[2*TIME_W-1:TIME_W]         = now;
        beat[2*TIME_W +: ACC_W]         = acc;
        beat[2*TIME_W+ACC_W +: LAT_W]   = fill;
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= beat;
        i_s_tuser  <= op;
        @(posedge i_clk);
        while (!o_s_tready)
            @(posedge i_clk);
        sent_count++;
        @(negedge i_clk);
    endtask

    // leaves i_cfg_valid high; the caller drops it after its last write
    task automatic write_register(input logic [CFG_IDX_W-1:0]  idx,
                                  input logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // every result back, then an idle wait for good measure
    task automatic wait_drained();
        wait (pending == 0);
        @(negedge i_clk);
        repeat (REQ_CYCLES + 4) @(negedge i_clk);
    endtask

    initial begin : stimulus
        logic [CFG_DATA_W-1:0] offset_data;
        logic [CFG_DATA_W-1:0] latency_data;

        tag_pool[0] = '0;
        tag_pool[1] = '1;
        for (int i = 2; i < POOL; i++)
            tag_pool[i] = {$urandom, $urandom};

        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed part at the reset settings: offset 6 and the reset hit latency
        send_request(OP_READ, '0, '0, '0, '0);                         // miss, empty set
        send_request(OP_INSTALL, line_address(5, 1), 100, 0, 50);      // ready at 150
        send_request(OP_READ, line_address(5, 1), 110, 32'hFFFF_FFF0, 0); // filling, saturates
        send_request(OP_READ, line_address(5, 1), 200, 5, 0);          // ready hit
        send_request(OP_WRITE, line_address(5, 1), 210, 0, 0);         // write hit, dirty
        for (int k = 1; k < WAYS; k++)                                  // fill the rest of set 1
            send_request(OP_INSTALL, line_address(10 + k, 1), 220 + 10 * k, 0, 0);
        send_request(OP_INSTALL, line_address(30, 1), 300, 0, 7);      // evicts dirty way 0
        send_request(OP_WRITE, line_address(2, 2), 310, 0, 0);         // write miss, empty set
        send_request(OP_WRITE, line_address(31, 1), 320, 0, 0);        // write miss, clean victim
        send_request(OP_INSTALL, line_address(2, 2), 330, 0, 3);       // tag already present
        send_request(OP_UNDEFINED, '1, '1, '1, '1);                    // undefined operation
        send_request(OP_INSTALL, line_address(40, 3), 64'hFFFF_FFFF_FFFF_FF00, 0, '1); // wraps
        send_request(OP_READ, line_address(40, 3), 64'hFFFF_FFFF_FFFF_FFFE, 7, 0);
        send_request(OP_INSTALL, line_address(41, 4), 1000, 0, 500);
        send_request(OP_WRITE, line_address(41, 4), 1010, 0, 0);       // write hit while filling
        send_request(OP_READ, '1, '1, '1, '1);                         // miss, everything maxed
        send_request(OP_WRITE, '1, '0, '1, '1);                        // write leaves time alone
        send_request(OP_INSTALL, line_address(42, 5), 64'h100_0000_0000, 0, 9);
        send_request(OP_READ, line_address(42, 5), '0, 3, 0);          // wait beyond 32 bits
        i_s_tvalid <= 1'b0;
        wait_drained();

        // random part over several register settings
        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0:       begin offset_data = 0;      latency_data = 0;  end
                1:       begin offset_data = 12;     latency_data = '1; end
                2:       begin offset_data = '1;     latency_data = 513; end  // offset 15
                3:       begin offset_data = 3;
                               latency_data = CFG_DATA_W'($urandom_range(2, 1022)); end
                default: begin offset_data = RESET_OFFSET; latency_data = 1; end
            endcase
            write_register(CFG_LINE_OFFSET, offset_data);
            write_register(CFG_HIT_LATENCY, latency_data);
            i_cfg_valid <= 1'b0;
            cur_offset = offset_data[OFF_W-1:0];
            @(negedge i_clk);

            for (int n = 0; n < PHASE_ITEMS; n++)
                send_request(pick_op(), pick_address(), pick_now(), pick_time(),
                             ($urandom_range(0, 99) < 30) ? LAT_W'($urandom_range(0, 20))
                                                          : LAT_W'($urandom_range(0, 1023)));
            i_s_tvalid <= 1'b0;
            wait_drained();
        end

        $display("%0d requests over %0d register settings, %0d predicted hits",
                 sent_count, PHASES + 1, hit_total);
        $display("%0d lines evicted, %0d of them dirty", eviction_total, dirty_eviction_total);
        if (mismatch_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
